[src/bspl_pkg.sv]
// ----------------------------------------------------------------------------
// B-spline basis evaluator package
// Shared constants, codes and the sequencer state type of the evaluator.
// ----------------------------------------------------------------------------
package bspl_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned KNOT_COUNT_DEF = 32;
  localparam int unsigned MAX_DEGREE_DEF = 3;
  localparam int unsigned KNOT_BITS_DEF  = 10;

  // Fixed field widths.
  localparam int unsigned T_W     = 10;
  localparam int unsigned BASIS_W = 20;

  // Intermediate basis values are kept signed and clamped to +-2^40.
  localparam int unsigned VAL_W = 42;

  localparam longint ONE_Q16   = 64'sd65536;
  localparam longint BASIS_MAX = 64'sd524288;
  localparam longint WIDE_LIM  = 64'sd1 << 40;

  // Item modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_RD,
    S_INIT_CMP,
    S_TERM_RD,
    S_TERM_MUL,
    S_DIV_PREP,
    S_DIV,
    S_ACC,
    S_STORE,
    S_OUT
  } bspl_state_e;

endpackage

[src/bspline_basis_eval.sv]
// ----------------------------------------------------------------------------
// B-spline basis evaluator
// Cox-de Boor recursion over a stored knot vector, one shared divider.
// ----------------------------------------------------------------------------
// A write item stores one knot and produces no result. An evaluate item
// builds the basis triangle bottom-up: the degree-zero row first, then
// d(d+1) terms for degree d, each through the divider save a term over a
// zero span, which skips it, with a store after each finished value, and
// last the result is issued; an index error goes straight to the result.
// The restoring divider retires two quotient bits per cycle and is shared
// by every term. The block takes no new item while an evaluation runs, but
// a finished result may wait in the output register while the next item
// is accepted.
module bspline_basis_eval
  import bspl_pkg::*;
#(
  parameter int unsigned KNOT_COUNT = KNOT_COUNT_DEF,
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned KNOT_BITS  = KNOT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         mode_i,
  input  logic [4:0]   knot_index_i,
  input  logic [9:0]   knot_value_i,
  input  logic [1:0]   degree_i,
  input  logic [4:0]   point_index_i,
  input  logic [9:0]   param_value_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [19:0]  basis_value_o,
  output logic         index_error_o
);

  localparam int unsigned AW        = $clog2(KNOT_COUNT);
  localparam int unsigned SLOTS     = MAX_DEGREE + 1;
  localparam int unsigned DEG_W     = $clog2(SLOTS);
  localparam int unsigned NUM_W     = ((KNOT_BITS > T_W) ? KNOT_BITS : T_W) + 1;
  localparam int unsigned SPAN_W    = KNOT_BITS + 1;
  localparam int unsigned PROD_W    = VAL_W + NUM_W;
  localparam int unsigned DIV_STEPS = PROD_W / 2;
  localparam int unsigned QW        = 2 * DIV_STEPS;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned ACC_W     = QW + 2;

  localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(ONE_Q16);
  localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(WIDE_LIM);
  localparam logic signed [VAL_W-1:0] VAL_LIM = VAL_W'(WIDE_LIM);

  bspl_state_e state_q, state_d;

  // Knot store with per-entry valid bits; an entry never written reads zero.
  logic [KNOT_BITS-1:0]  knot_mem [KNOT_COUNT];
  logic [KNOT_COUNT-1:0] knot_vld_q;
  logic [KNOT_BITS-1:0]  knot_lo_q, knot_hi_q;
  logic                  lo_vld_q, hi_vld_q;
  logic [AW-1:0]         rd_lo_addr, rd_hi_addr, wr_addr;
  logic [KNOT_BITS-1:0]  wr_data;
  logic                  knot_we;
  logic [KNOT_BITS-1:0]  knot_lo, knot_hi;

  // Sequencer and item registers.
  logic [DEG_W-1:0] j_q, lvl_q, deg_q, last_j, deg_in, child_idx;
  logic             lower_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AW-1:0]    p_q;
  logic [T_W-1:0]   t_q;
  logic             err_q;
  logic             idx_bad, eval_go, out_load;

  logic signed [VAL_W-1:0] slot_q [SLOTS];

  // Term datapath.
  logic signed [NUM_W-1:0]  lo_n, hi_n, t_n, num;
  logic signed [SPAN_W-1:0] span;
  logic [KNOT_BITS-1:0]     den;
  logic signed [VAL_W-1:0]  child;
  logic signed [PROD_W-1:0] prod_w, prod_q, prod_mag;
  logic [KNOT_BITS-1:0]     den_q;
  logic                     span_neg_q, zero_q, neg_q;

  // Divider and accumulator.
  logic [QW-1:0]            quo_q, quo_nx;
  logic [KNOT_BITS-1:0]     rem_q, rem_nx;
  logic [KNOT_BITS:0]       trial;
  logic signed [ACC_W-1:0]  acc_q, acc_base, quo_ext;
  logic signed [VAL_W-1:0]  acc_clamped;

  logic                     out_valid_q;
  logic [BASIS_W-1:0]       basis_q;
  logic                     index_err_q;

  // --------------------------------------------------------------------------
  // Item decode
  // --------------------------------------------------------------------------
  always_comb begin
    deg_in  = (32'(degree_i) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(degree_i);
    idx_bad = (32'(point_index_i) + 32'(deg_in) + 32'd1) >= KNOT_COUNT;
    wr_addr = AW'(knot_index_i);
    wr_data = KNOT_BITS'(knot_value_i);
    last_j  = deg_q - lvl_q;
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && mode_i == MODE_EVAL) begin
          state_d = idx_bad ? S_OUT : S_INIT_RD;
        end
      end
      S_INIT_RD:  state_d = S_INIT_CMP;
      S_INIT_CMP: begin
        if (j_q == deg_q) begin
          state_d = (deg_q == '0) ? S_OUT : S_TERM_RD;
        end else begin
          state_d = S_INIT_RD;
        end
      end
      S_TERM_RD:  state_d = S_TERM_MUL;
      S_TERM_MUL: state_d = S_DIV_PREP;
      S_DIV_PREP: state_d = zero_q ? S_ACC : S_DIV;
      S_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_ACC;
      end
      S_ACC:      state_d = lower_q ? S_STORE : S_TERM_RD;
      S_STORE: begin
        state_d = (j_q == last_j && lvl_q == deg_q) ? S_OUT : S_TERM_RD;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    eval_go    = (state_q == S_IDLE) && in_valid_i && (mode_i == MODE_EVAL);
    knot_we    = (state_q == S_IDLE) && in_valid_i && (mode_i == MODE_WRITE) &&
                 (32'(knot_index_i) < KNOT_COUNT);
    out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
    // The upper term of B(k, p+j) spans knots p+j+1 .. p+j+k+1, the lower
    // one p+j .. p+j+k; the degree-zero row compares knots p+j and p+j+1.
    if (state_q == S_INIT_RD) begin
      rd_lo_addr = AW'(32'(p_q) + 32'(j_q));
      rd_hi_addr = AW'(32'(p_q) + 32'(j_q) + 32'd1);
    end else begin
      rd_lo_addr = AW'(32'(p_q) + 32'(j_q) + (lower_q ? 32'd0 : 32'd1));
      rd_hi_addr = AW'(32'(p_q) + 32'(j_q) + (lower_q ? 32'd0 : 32'd1) + 32'(lvl_q));
    end
    child_idx  = lower_q ? j_q : DEG_W'({1'b0, j_q} + 1'b1);
  end

  // --------------------------------------------------------------------------
  // Knot store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (knot_we) knot_mem[wr_addr] <= wr_data;
    knot_lo_q <= knot_mem[rd_lo_addr];
    knot_hi_q <= knot_mem[rd_hi_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_vld_q <= '0;
      lo_vld_q   <= 1'b0;
      hi_vld_q   <= 1'b0;
    end else begin
      if (knot_we) knot_vld_q[wr_addr] <= 1'b1;
      lo_vld_q <= knot_vld_q[rd_lo_addr];
      hi_vld_q <= knot_vld_q[rd_hi_addr];
    end
  end

  assign knot_lo = lo_vld_q ? knot_lo_q : '0;
  assign knot_hi = hi_vld_q ? knot_hi_q : '0;

  // --------------------------------------------------------------------------
  // Term arithmetic
  // --------------------------------------------------------------------------
  always_comb begin
    lo_n   = $signed({{(NUM_W - KNOT_BITS){1'b0}}, knot_lo});
    hi_n   = $signed({{(NUM_W - KNOT_BITS){1'b0}}, knot_hi});
    t_n    = $signed({{(NUM_W - T_W){1'b0}}, t_q});
    span   = $signed({1'b0, knot_hi}) - $signed({1'b0, knot_lo});
    den    = span[SPAN_W-1] ? KNOT_BITS'(-span) : KNOT_BITS'(span);
    num    = lower_q ? (t_n - lo_n) : (hi_n - t_n);
    child  = slot_q[child_idx];
    prod_w = PROD_W'(num) * PROD_W'(child);
    prod_mag = prod_q[PROD_W-1] ? -prod_q : prod_q;
  end

  // Restoring division on magnitudes, two quotient bits per cycle.
  always_comb begin
    rem_nx = rem_q;
    quo_nx = quo_q;
    trial  = '0;
    for (int i = 0; i < 2; i++) begin
      trial  = {rem_nx, quo_nx[QW-1]};
      quo_nx = {quo_nx[QW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial     = trial - {1'b0, den_q};
        quo_nx[0] = 1'b1;
      end
      rem_nx = trial[KNOT_BITS-1:0];
    end
  end

  always_comb begin
    acc_base = lower_q ? acc_q : '0;
    quo_ext  = $signed({2'b00, quo_q});
    if (acc_q > ACC_LIM) begin
      acc_clamped = VAL_LIM;
    end else if (acc_q < -ACC_LIM) begin
      acc_clamped = -VAL_LIM;
    end else begin
      acc_clamped = VAL_W'(acc_q);
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      j_q         <= '0;
      lvl_q       <= '0;
      lower_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (eval_go) begin
            j_q     <= '0;
            lvl_q   <= '0;
            lower_q <= 1'b0;
          end
        end
        S_INIT_CMP: begin
          if (j_q == deg_q) begin
            j_q   <= '0;
            lvl_q <= DEG_W'(1);
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_DIV_PREP: cnt_q <= '0;
        S_DIV:      cnt_q <= cnt_q + 1'b1;
        S_ACC: begin
          if (!lower_q) lower_q <= 1'b1;
        end
        S_STORE: begin
          lower_q <= 1'b0;
          if (j_q == last_j) begin
            j_q   <= '0;
            lvl_q <= lvl_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (eval_go) begin
          p_q   <= AW'(point_index_i);
          deg_q <= deg_in;
          t_q   <= param_value_i;
          err_q <= idx_bad;
        end
      end
      S_INIT_CMP: begin
        // Both ends of the degree-zero interval are closed.
        slot_q[j_q] <= (lo_n <= t_n && t_n <= hi_n) ? VAL_ONE : '0;
      end
      S_TERM_MUL: begin
        prod_q     <= prod_w;
        den_q      <= den;
        span_neg_q <= span[SPAN_W-1];
        zero_q     <= (span == '0);
      end
      S_DIV_PREP: begin
        quo_q <= zero_q ? '0 : QW'(prod_mag);
        rem_q <= '0;
        neg_q <= prod_q[PROD_W-1] ^ span_neg_q;
      end
      S_DIV: begin
        quo_q <= quo_nx;
        rem_q <= rem_nx;
      end
      S_ACC: begin
        acc_q <= neg_q ? (acc_base - quo_ext) : (acc_base + quo_ext);
      end
      S_STORE: begin
        slot_q[j_q] <= acc_clamped;
      end
      S_OUT: begin
        if (out_load) begin
          index_err_q <= err_q;
          if (err_q || slot_q[0] < 0) begin
            basis_q <= '0;
          end else if (slot_q[0] > VAL_W'(BASIS_MAX)) begin
            basis_q <= BASIS_W'(BASIS_MAX);
          end else begin
            basis_q <= BASIS_W'(slot_q[0]);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign basis_value_o = basis_q;
  assign index_error_o = index_err_q;

endmodule

[src/bspl_checker.sv]
// ----------------------------------------------------------------------------
// B-spline basis evaluator checker
// Port-level properties of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bspl_checker
  import bspl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [19:0] basis_value_o,
  input logic        index_error_o
);

  // A waiting result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(basis_value_o) && $stable(index_error_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 64'(basis_value_o) <= BASIS_MAX)
    else $error("basis value above saturation limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> basis_value_o == '0)
    else $error("index error with a non-zero value");

  // An evaluation occupies the block; a knot write does not.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == MODE_EVAL |=> !in_ready_o)
    else $error("ready right after an evaluate transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == MODE_WRITE |=> in_ready_o)
    else $error("not ready after a knot write");

endmodule

bind bspline_basis_eval bspl_checker u_bspl_checker (.*);
